>>> hw/rtl/prbw_pkg.sv
package prbw_pkg;

  // grid sizes are powers of two, given by their log2
  localparam int unsigned GRID_X_LOG2 = 4;
  localparam int unsigned GRID_Y_LOG2 = 4;
  localparam int unsigned GRID_Z_LOG2 = 4;
  localparam int unsigned GRID_LOG2 [3] = '{GRID_X_LOG2, GRID_Y_LOG2, GRID_Z_LOG2};

  localparam int unsigned WRAP_W_RAW =
    (GRID_X_LOG2 >= GRID_Y_LOG2 && GRID_X_LOG2 >= GRID_Z_LOG2) ? GRID_X_LOG2 :
    (GRID_Y_LOG2 >= GRID_Z_LOG2) ? GRID_Y_LOG2 : GRID_Z_LOG2;
  localparam int unsigned WRAP_W = (WRAP_W_RAW == 0) ? 1 : WRAP_W_RAW;

  localparam int unsigned Q_W     = 32;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned IMG_W   = 12;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned DIFF_W  = 35;
  localparam int unsigned MAG_W   = 34;
  localparam int unsigned PROD_W  = MAG_W + 16;
  localparam int unsigned CFG_AW  = 3;

  typedef enum logic [1:0] {
    KIND_SPHERE  = 2'd0,
    KIND_BOX     = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_SCALE_X  = 3'd3,
    CFG_SCALE_Y  = 3'd4,
    CFG_SCALE_Z  = 3'd5,
    CFG_PERIODIC = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic signed [31:0]    first_x;
    logic signed [31:0]    first_y;
    logic signed [31:0]    first_z;
    logic [30:0]           radius;
    logic signed [31:0]    second_x;
    logic signed [31:0]    second_y;
    logic signed [31:0]    second_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        block_index;
    logic signed [IMG_W-1:0] image_x;
    logic signed [IMG_W-1:0] image_y;
    logic signed [IMG_W-1:0] image_z;
    logic                    done_res;
  } out_item_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] origin;
    logic [2:0][Q_W-1:0] scale;
    logic [2:0]          periodic;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic [WRAP_W-1:0]         wrap;
    logic signed [IMG_W-1:0]   image;
  } axis_cmd_t;

  typedef struct packed {
    logic                is_start;
    axis_cmd_t [2:0]     axis;
  } cmd_t;

endpackage

>>> hw/rtl/prbw_front.sv
module prbw_front import prbw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic a_valid_in;

  logic a_start_r, b_start_r, c_start_r;
  logic signed [DIFF_W-1:0]  a_d_r   [6];
  logic signed [DIFF_W-1:0]  a_d_nxt [6];
  logic                      b_neg_r [6];
  logic                      b_neg_nxt [6];
  logic [PROD_W-1:0]         b_ph_r  [6];
  logic [PROD_W-1:0]         b_pl_r  [6];
  logic [PROD_W-1:0]         b_ph_nxt [6];
  logic [PROD_W-1:0]         b_pl_nxt [6];
  logic signed [COORD_W-1:0] c_co_r  [6];
  logic signed [COORD_W-1:0] c_co_nxt [6];
  cmd_t                      d_cmd_r;
  cmd_t                      d_cmd_nxt;

  logic signed [31:0] first  [3];
  logic signed [31:0] second [3];

  assign rdy_d = !vd_r || !cmd_full;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign full  = !rdy_a;

  assign cmd_push = vd_r && !cmd_full;
  assign cmd      = d_cmd_r;

  assign a_valid_in = push && (in_item.kind == KIND_SPHERE || in_item.kind == KIND_BOX ||
                               in_item.kind == KIND_ADVANCE);

  assign first[0]  = in_item.first_x;
  assign first[1]  = in_item.first_y;
  assign first[2]  = in_item.first_z;
  assign second[0] = in_item.second_x;
  assign second[1] = in_item.second_y;
  assign second[2] = in_item.second_z;

  // bound differences relative to origin
  always_comb begin
    logic signed [DIFF_W-1:0] org;
    logic signed [DIFF_W-1:0] base;
    logic signed [DIFF_W-1:0] rad;
    rad = $signed(DIFF_W'(in_item.radius));
    for (int ax = 0; ax < 3; ax++) begin
      org  = DIFF_W'($signed(cfg.origin[ax]));
      base = DIFF_W'(first[ax]) - org;
      if (in_item.kind == KIND_SPHERE) begin
        a_d_nxt[2*ax]   = base - rad;
        a_d_nxt[2*ax+1] = base + rad;
      end else begin
        a_d_nxt[2*ax]   = base;
        a_d_nxt[2*ax+1] = DIFF_W'(second[ax]) - org;
      end
    end
  end

  // magnitude times scale, split into high and low halves of the scale
  always_comb begin
    logic [MAG_W-1:0] m;
    logic [Q_W-1:0]   sc;
    for (int k = 0; k < 6; k++) begin
      sc           = cfg.scale[k/2];
      b_neg_nxt[k] = a_d_r[k][DIFF_W-1];
      m            = b_neg_nxt[k] ? MAG_W'(-a_d_r[k]) : MAG_W'(a_d_r[k]);
      b_ph_nxt[k]  = PROD_W'(m) * PROD_W'(sc[31:16]);
      b_pl_nxt[k]  = PROD_W'(m) * PROD_W'(sc[15:0]);
    end
  end

  // integer part with floor quirk and saturation
  always_comb begin
    logic [PROD_W:0]   t;
    logic [DIFF_W-1:0] ip;
    logic              frac;
    for (int k = 0; k < 6; k++) begin
      t    = (PROD_W+1)'({b_ph_r[k][15:0], 16'h0000}) + (PROD_W+1)'(b_pl_r[k]);
      ip   = DIFF_W'(b_ph_r[k][PROD_W-1:16]) + DIFF_W'(t[PROD_W:32]);
      frac = |t[31:0];
      priority if (!b_neg_r[k]) begin
        c_co_nxt[k] = (ip > DIFF_W'(32767)) ? 16'sh7FFF : $signed(ip[COORD_W-1:0]);
      end else if (ip == '0 && !frac) begin
        c_co_nxt[k] = '0;
      end else if (ip >= DIFF_W'(32767)) begin
        c_co_nxt[k] = 16'sh8000;
      end else begin
        c_co_nxt[k] = $signed(~ip[COORD_W-1:0]);
      end
    end
  end

  // clamp or wrap per axis
  always_comb begin
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic signed [COORD_W-1:0] n_m1;
    logic signed [COORD_W-1:0] sh;
    d_cmd_nxt          = '0;
    d_cmd_nxt.is_start = c_start_r;
    for (int ax = 0; ax < 3; ax++) begin
      lo   = c_co_r[2*ax];
      hi   = c_co_r[2*ax+1];
      n_m1 = $signed(COORD_W'((1 << GRID_LOG2[ax]) - 1));
      if (!cfg.periodic[ax]) begin
        if (lo < 0) begin
          lo = '0;
          if (hi < 0) hi = '0;
        end
        if (hi > n_m1) begin
          hi = n_m1;
          if (lo > n_m1) lo = n_m1;
        end
      end
      sh = lo >>> GRID_LOG2[ax];
      d_cmd_nxt.axis[ax].lo   = lo;
      d_cmd_nxt.axis[ax].hi   = hi;
      d_cmd_nxt.axis[ax].wrap = WRAP_W'(lo & n_m1);
      priority if (sh > 16'sd2047) begin
        d_cmd_nxt.axis[ax].image = 12'sh7FF;
      end else if (sh < -16'sd2048) begin
        d_cmd_nxt.axis[ax].image = 12'sh800;
      end else begin
        d_cmd_nxt.axis[ax].image = sh[IMG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= a_valid_in;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_start_r <= (in_item.kind != KIND_ADVANCE);
      a_d_r     <= a_d_nxt;
    end
    if (rdy_b) begin
      b_start_r <= a_start_r;
      b_neg_r   <= b_neg_nxt;
      b_ph_r    <= b_ph_nxt;
      b_pl_r    <= b_pl_nxt;
    end
    if (rdy_c) begin
      c_start_r <= b_start_r;
      c_co_r    <= c_co_nxt;
    end
    if (rdy_d) begin
      d_cmd_r <= d_cmd_nxt;
    end
  end

endmodule

>>> hw/rtl/prbw_cmd_queue.sv
module prbw_cmd_queue import prbw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic cq_full,
  input  logic pop,
  output cmd_t head_cmd,
  output logic cq_empty
);

  localparam int unsigned CQ_AW    = 2;
  localparam int unsigned CQ_DEPTH = 1 << CQ_AW;

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_r, wr_nxt;
  logic [CQ_AW-1:0] rd_r, rd_nxt;
  logic [CQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign cq_full  = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign cq_empty = (cnt_r == '0);
  assign head_cmd = mem_r[rd_r];
  assign do_push  = push && !cq_full;
  assign do_pop   = pop && !cq_empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (CQ_AW+1)'(do_push) - (CQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_cmd;
  end

endmodule

>>> hw/rtl/prbw_back.sv
module prbw_back import prbw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head_cmd,
  input  logic      cq_empty,
  output logic      take,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic                      walking_r, walking_nxt;
  logic signed [COORD_W-1:0] lo_r    [3];
  logic signed [COORD_W-1:0] hi_r    [3];
  logic signed [COORD_W-1:0] pos_r   [3];
  logic signed [COORD_W-1:0] pos_nxt [3];
  logic [WRAP_W-1:0]         wrap_r  [3];
  logic [WRAP_W-1:0]         wrap_nxt [3];
  logic [WRAP_W-1:0]         swrap_r [3];
  logic signed [IMG_W-1:0]   simg_r  [3];
  logic signed [IMG_W-1:0]   cimg_r  [3];
  logic signed [IMG_W-1:0]   cimg_nxt [3];

  out_item_t ob_mem_r [2];
  logic      ob_wr_r, ob_rd_r;
  logic [1:0] ob_cnt_r, ob_cnt_nxt;
  logic      ob_pop;
  out_item_t res;

  logic [2:0] adv, do_step, do_restart;
  logic       done;

  function automatic logic [IDX_W-1:0] linear_index(input logic [WRAP_W-1:0] wx,
                                                    input logic [WRAP_W-1:0] wy,
                                                    input logic [WRAP_W-1:0] wz);
    logic [31:0] s;
    s = 32'(wx) + (32'(wy) << GRID_X_LOG2) + (32'(wz) << (GRID_X_LOG2 + GRID_Y_LOG2));
    return s[IDX_W-1:0];
  endfunction

  assign take     = !cq_empty && (ob_cnt_r != 2'd2);
  assign ob_pop   = pop && (ob_cnt_r != 2'd0);
  assign empty    = (ob_cnt_r == 2'd0);
  assign out_item = ob_mem_r[ob_rd_r];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) adv[ax] = pos_r[ax] < hi_r[ax];
  end

  always_comb begin
    walking_nxt = walking_r;
    do_step     = '0;
    do_restart  = '0;
    done        = 1'b0;
    if (take && !head_cmd.is_start) begin
      priority if (!walking_r) begin
        done = 1'b1;
      end else if (adv[0]) begin
        do_step = 3'b001;
      end else if (adv[1]) begin
        do_restart = 3'b001;
        do_step    = 3'b010;
      end else if (adv[2]) begin
        do_restart = 3'b011;
        do_step    = 3'b100;
      end else begin
        walking_nxt = 1'b0;
        done        = 1'b1;
      end
    end else if (take) begin
      walking_nxt = 1'b1;
    end
  end

  always_comb begin
    logic [WRAP_W-1:0] n_m1;
    for (int ax = 0; ax < 3; ax++) begin
      n_m1          = WRAP_W'((1 << GRID_LOG2[ax]) - 1);
      pos_nxt[ax]   = pos_r[ax];
      wrap_nxt[ax]  = wrap_r[ax];
      cimg_nxt[ax]  = cimg_r[ax];
      if (take && head_cmd.is_start) begin
        pos_nxt[ax]  = head_cmd.axis[ax].lo;
        wrap_nxt[ax] = head_cmd.axis[ax].wrap;
        cimg_nxt[ax] = head_cmd.axis[ax].image;
      end
      if (do_restart[ax]) begin
        pos_nxt[ax]  = lo_r[ax];
        wrap_nxt[ax] = swrap_r[ax];
        cimg_nxt[ax] = simg_r[ax];
      end
      if (do_step[ax]) begin
        pos_nxt[ax] = pos_r[ax] + 16'sd1;
        if (wrap_r[ax] < n_m1) begin
          wrap_nxt[ax] = wrap_r[ax] + 1'b1;
        end else begin
          wrap_nxt[ax] = '0;
          if (cimg_r[ax] != 12'sh7FF) cimg_nxt[ax] = cimg_r[ax] + 12'sd1;
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (done) begin
      res.done_res = 1'b1;
    end else begin
      res.block_index = linear_index(wrap_nxt[0], wrap_nxt[1], wrap_nxt[2]);
      res.image_x     = cimg_nxt[0];
      res.image_y     = cimg_nxt[1];
      res.image_z     = cimg_nxt[2];
    end
  end

  assign ob_cnt_nxt = ob_cnt_r + 2'(take) - 2'(ob_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r <= 1'b0;
      ob_wr_r   <= 1'b0;
      ob_rd_r   <= 1'b0;
      ob_cnt_r  <= 2'd0;
      for (int ax = 0; ax < 3; ax++) begin
        lo_r[ax]    <= '0;
        hi_r[ax]    <= '0;
        pos_r[ax]   <= '0;
        wrap_r[ax]  <= '0;
        swrap_r[ax] <= '0;
        simg_r[ax]  <= '0;
        cimg_r[ax]  <= '0;
      end
    end else begin
      walking_r <= walking_nxt;
      ob_cnt_r  <= ob_cnt_nxt;
      if (take)   ob_wr_r <= ~ob_wr_r;
      if (ob_pop) ob_rd_r <= ~ob_rd_r;
      pos_r  <= pos_nxt;
      wrap_r <= wrap_nxt;
      cimg_r <= cimg_nxt;
      if (take && head_cmd.is_start) begin
        for (int ax = 0; ax < 3; ax++) begin
          lo_r[ax]    <= head_cmd.axis[ax].lo;
          hi_r[ax]    <= head_cmd.axis[ax].hi;
          swrap_r[ax] <= head_cmd.axis[ax].wrap;
          simg_r[ax]  <= head_cmd.axis[ax].image;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) ob_mem_r[ob_wr_r] <= res;
  end

endmodule

>>> hw/rtl/periodic_block_range_walker.sv
// Walks the grid blocks covering a sphere or box query, one block per item. A start item
// (kind 0 sphere, kind 1 box) yields the first block and its periodic image counts; each
// advance item (kind 2) yields the next block, x fastest, or a done result; kind 3 is
// consumed with no result. One item is taken per clock cycle sustained when nothing stalls.
// A result becomes visible once its item has passed the front coordinate pipeline stages
// (offset, scale multiply, floor and saturate, clamp and wrap), the command queue, and the
// back-end walk state update with its result register; the back end also sets the
// one-item-per-cycle pace, and it stalls while the result buffer is full or the queue empty.
// A four-entry command queue and a two-entry result buffer let either side stall.
// Configuration writes take effect at once and are to be made only while the block is idle.
module periodic_block_range_walker import prbw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [Q_W-1:0]    cfg_wdata,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item,
  input  logic              pop,
  output logic              empty,
  output out_item_t         out_item
);

  cfg_t cfg_r, cfg_nxt;
  logic cmd_push, cq_full, cq_empty, take;
  cmd_t cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_ORIGIN_X: cfg_nxt.origin[0] = cfg_wdata;
        CFG_ORIGIN_Y: cfg_nxt.origin[1] = cfg_wdata;
        CFG_ORIGIN_Z: cfg_nxt.origin[2] = cfg_wdata;
        CFG_SCALE_X:  cfg_nxt.scale[0]  = cfg_wdata;
        CFG_SCALE_Y:  cfg_nxt.scale[1]  = cfg_wdata;
        CFG_SCALE_Z:  cfg_nxt.scale[2]  = cfg_wdata;
        CFG_PERIODIC: cfg_nxt.periodic  = cfg_wdata[2:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin   <= '0;
      cfg_r.scale    <= {3{32'h0001_0000}};
      cfg_r.periodic <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prbw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .cmd_full (cq_full)
  );

  prbw_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .cq_full  (cq_full),
    .pop      (take),
    .head_cmd (head_cmd),
    .cq_empty (cq_empty)
  );

  prbw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .cq_empty (cq_empty),
    .take     (take),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  a_no_queue_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cq_full |-> !cmd_push)
    else $error("command queue overrun");

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !cq_empty)
    else $error("back end took from empty queue");

  a_full_means_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> cq_full)
    else $error("input stalled while command queue has room");

  a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.done_res) |-> (out_item.block_index == '0 &&
      out_item.image_x == '0 && out_item.image_y == '0 && out_item.image_z == '0))
    else $error("done result carries nonzero fields");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import prbw_pkg::*;

  localparam int ONE = 65536;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS = 200;
  localparam int NUM_SEGS = 9;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int AXIS_LEN [3] = '{1 << GRID_X_LOG2, 1 << GRID_Y_LOG2, 1 << GRID_Z_LOG2};

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [Q_W-1:0]    cfg_wdata;
  logic              push;
  logic              full;
  in_item_t          in_item;
  logic              pop;
  logic              empty;
  out_item_t         out_item;

  // register mirror
  logic signed [31:0] cfg_origin [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic [31:0]        cfg_scale [3] = '{32'h10000, 32'h10000, 32'h10000};
  logic [2:0]         cfg_periodic = 3'd0;

  // walk state
  int walk_lo [3];
  int walk_hi [3];
  int walk_pos [3];
  int wrap_pos [3];
  int wrap_start [3];
  int image_start [3];
  int image_cur [3];
  bit walking;

  in_item_t  pending_items [$];
  out_item_t expected_blocks [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int shown_count;
  int blocks_checked;
  int n_starts;
  int n_advances;
  int n_settings;
  int stall_cycles;

  periodic_block_range_walker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat_image(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int floor_mod(int a, int n);
    if (a >= 0) return a % n;
    return n - 1 - (n - 1 - a) % n;
  endfunction

  function automatic int floor_div(int a, int n);
    if (a >= 0) return a / n;
    return -1 - ((-(a + 1)) / n);
  endfunction

  // floor of diff * sc in Q16.16, negative exact integers one lower, saturated to 16 bits
  function automatic int block_coord(longint diff, logic [31:0] sc);
    logic [63:0] m, a, b, t, ip;
    bit neg;
    neg = (diff < 0);
    m = neg ? 64'(-diff) : 64'(diff);
    a = m * 64'(sc[31:16]);
    b = m * 64'(sc[15:0]);
    t = 64'({a[15:0], 16'd0}) + b;
    ip = (a >> 16) + (t >> 32);
    if (!neg) return (ip > 64'd32767) ? 32767 : int'(ip);
    if (ip == 64'd0 && t[31:0] == 32'd0) return 0;
    if (ip >= 64'd32767) return -32768;
    return -int'(ip) - 1;
  endfunction

  function automatic void start_axis(int ax, int lo, int hi);
    int n;
    n = AXIS_LEN[ax];
    if (!cfg_periodic[ax]) begin
      if (lo < 0) begin
        lo = 0;
        if (hi < 0) hi = 0;
      end
      if (hi >= n) begin
        hi = n - 1;
        if (lo >= n) lo = n - 1;
      end
    end
    walk_lo[ax] = lo;
    walk_hi[ax] = hi;
    walk_pos[ax] = lo;
    wrap_pos[ax] = floor_mod(lo, n);
    wrap_start[ax] = wrap_pos[ax];
    image_start[ax] = sat_image(floor_div(lo, n));
    image_cur[ax] = image_start[ax];
  endfunction

  function automatic void restart_axis(int ax);
    walk_pos[ax] = walk_lo[ax];
    wrap_pos[ax] = wrap_start[ax];
    image_cur[ax] = image_start[ax];
  endfunction

  function automatic void step_axis(int ax);
    walk_pos[ax]++;
    if (wrap_pos[ax] < AXIS_LEN[ax] - 1) begin
      wrap_pos[ax]++;
    end else begin
      wrap_pos[ax] = 0;
      image_cur[ax] = sat_image(image_cur[ax] + 1);
    end
  endfunction

  function automatic void walk_predict(in_item_t it);
    out_item_t res;
    logic signed [31:0] first [3];
    logic signed [31:0] second [3];
    longint base, lo, hi;
    int idx;
    res = '0;
    first[0] = it.first_x;
    first[1] = it.first_y;
    first[2] = it.first_z;
    second[0] = it.second_x;
    second[1] = it.second_y;
    second[2] = it.second_z;
    if (it.kind == KIND_UNUSED) return;
    if (it.kind == KIND_ADVANCE) begin
      if (!walking) begin
        res.done_res = 1'b1;
      end else if (walk_pos[0] < walk_hi[0]) begin
        step_axis(0);
      end else if (walk_pos[1] < walk_hi[1]) begin
        restart_axis(0);
        step_axis(1);
      end else if (walk_pos[2] < walk_hi[2]) begin
        restart_axis(0);
        restart_axis(1);
        step_axis(2);
      end else begin
        walking = 1'b0;
        res.done_res = 1'b1;
      end
    end else begin
      for (int ax = 0; ax < 3; ax++) begin
        base = longint'(first[ax]) - longint'(cfg_origin[ax]);
        if (it.kind == KIND_SPHERE) begin
          lo = base - longint'(it.radius);
          hi = base + longint'(it.radius);
        end else begin
          lo = base;
          hi = longint'(second[ax]) - longint'(cfg_origin[ax]);
        end
        start_axis(ax, block_coord(lo, cfg_scale[ax]), block_coord(hi, cfg_scale[ax]));
      end
      walking = 1'b1;
    end
    if (!res.done_res) begin
      idx = wrap_pos[0] + AXIS_LEN[0] * (wrap_pos[1] + AXIS_LEN[1] * wrap_pos[2]);
      res.block_index = 12'(idx);
      res.image_x = 12'(image_cur[0]);
      res.image_y = 12'(image_cur[1]);
      res.image_z = 12'(image_cur[2]);
    end
    expected_blocks.push_back(res);
  endfunction

  // offset in Q16.16 that lands num (Q16.16 block units) away under the current scale
  function automatic logic [31:0] scaled_offset(int ax, longint num);
    if (cfg_scale[ax] == 32'd0) return num[31:0];
    return 32'((num * 64'sd65536) / longint'(cfg_scale[ax]));
  endfunction

  function automatic logic [31:0] near_coord(int ax);
    int k, frac;
    if ($urandom_range(0, 7) == 0) return $urandom;
    k = int'($urandom_range(0, 56)) - 20;
    frac = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 65535));
    return cfg_origin[ax] + scaled_offset(ax, longint'(k) * ONE + frac);
  endfunction

  function automatic in_item_t random_item();
    in_item_t r;
    r.kind = 2'($urandom);
    r.first_x = $urandom;
    r.first_y = $urandom;
    r.first_z = $urandom;
    r.radius = 31'($urandom);
    r.second_x = $urandom;
    r.second_y = $urandom;
    r.second_z = $urandom;
    return r;
  endfunction

  task automatic add_item(logic [1:0] k, int fx, int fy, int fz, int rad,
                          int sx, int sy, int sz);
    in_item_t it;
    it = random_item();
    it.kind = k;
    if (k != KIND_ADVANCE && k != KIND_UNUSED) begin
      it.first_x = fx;
      it.first_y = fy;
      it.first_z = fz;
      it.radius = 31'(rad);
      it.second_x = sx;
      it.second_y = sy;
      it.second_z = sz;
    end
    pending_items.push_back(it);
  endtask

  // mostly a start followed by a run of advances; sometimes a stray item
  task automatic add_random_seq(inout int counted);
    in_item_t it;
    int n_adv;
    it = random_item();
    if ($urandom_range(0, 9) == 0) begin
      pending_items.push_back(it);
      if (it.kind != KIND_UNUSED) counted++;
      return;
    end
    it.kind = $urandom_range(0, 1) ? KIND_BOX : KIND_SPHERE;
    it.first_x = near_coord(0);
    it.first_y = near_coord(1);
    it.first_z = near_coord(2);
    if (it.kind == KIND_SPHERE) begin
      if ($urandom_range(0, 15) != 0)
        it.radius = 31'(scaled_offset(0, longint'($urandom_range(0, 2 * ONE))));
    end else if ($urandom_range(0, 7) != 0) begin
      it.second_x = it.first_x + scaled_offset(0, int'($urandom_range(0, 4 * ONE)) - ONE / 2);
      it.second_y = it.first_y + scaled_offset(1, int'($urandom_range(0, 4 * ONE)) - ONE / 2);
      it.second_z = it.first_z + scaled_offset(2, int'($urandom_range(0, 4 * ONE)) - ONE / 2);
    end
    pending_items.push_back(it);
    counted++;
    n_adv = $urandom_range(0, 30);
    repeat (n_adv) begin
      if ($urandom_range(0, 19) == 0) begin
        it = random_item();
        it.kind = KIND_UNUSED;
        pending_items.push_back(it);
      end
      it = random_item();
      it.kind = KIND_ADVANCE;
      pending_items.push_back(it);
      counted++;
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ORIGIN_X: cfg_origin[0] = val;
      CFG_ORIGIN_Y: cfg_origin[1] = val;
      CFG_ORIGIN_Z: cfg_origin[2] = val;
      CFG_SCALE_X:  cfg_scale[0] = val;
      CFG_SCALE_Y:  cfg_scale[1] = val;
      CFG_SCALE_Z:  cfg_scale[2] = val;
      CFG_PERIODIC: cfg_periodic = val[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int sel);
    logic [31:0] org [3];
    logic [31:0] scl [3];
    logic [2:0] per;
    org = '{32'd0, 32'd0, 32'd0};
    scl = '{32'h10000, 32'h10000, 32'h10000};
    per = 3'd0;
    case (sel)
      1: per = 3'b111;
      2: begin
        for (int ax = 0; ax < 3; ax++)
          org[ax] = 32'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
        scl = '{32'h20000, 32'h8000, 32'h18000};
        per = 3'b101;
      end
      3: begin
        org = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
        scl = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h10000};
        per = 3'b010;
      end
      4: begin
        org = '{$urandom, $urandom, $urandom};
        scl = '{32'd0, 32'h10000, 32'hC000};
        per = 3'b011;
      end
      5: begin
        for (int ax = 0; ax < 3; ax++) begin
          org[ax] = 32'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
          scl[ax] = $urandom_range(32'h4000, 32'h40000);
        end
        per = 3'($urandom_range(0, 7));
      end
      default: ;
    endcase
    write_reg(CFG_ORIGIN_X, org[0]);
    write_reg(CFG_ORIGIN_Y, org[1]);
    write_reg(CFG_ORIGIN_Z, org[2]);
    write_reg(CFG_SCALE_X, scl[0]);
    write_reg(CFG_SCALE_Y, scl[1]);
    write_reg(CFG_SCALE_Z, scl[2]);
    write_reg(CFG_PERIODIC, {29'd0, per});
    @(negedge clk) cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_blocks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input side: push at falling edge, transfer seen at rising edge
  always @(negedge clk) begin
    if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      push <= 1'b1;
      in_item <= pending_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk) pop <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      walk_predict(in_item);
      if (in_item.kind == KIND_ADVANCE) n_advances++;
      else if (in_item.kind != KIND_UNUSED) n_starts++;
      void'(pending_items.pop_front());
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_blocks.size() == 0) begin
        fail_count++;
        if (shown_count < 10) begin
          shown_count++;
          $display("unexpected result at %0t: idx %0d img %0d/%0d/%0d done %0b", $realtime,
                   out_item.block_index, out_item.image_x, out_item.image_y,
                   out_item.image_z, out_item.done_res);
        end
      end else begin
        want = expected_blocks.pop_front();
        blocks_checked++;
        if (out_item.block_index !== want.block_index || out_item.image_x !== want.image_x ||
            out_item.image_y !== want.image_y || out_item.image_z !== want.image_z ||
            out_item.done_res !== want.done_res) begin
          fail_count++;
          if (shown_count < 10) begin
            shown_count++;
            $display("mismatch at %0t: expected idx %0d img %0d/%0d/%0d done %0b", $realtime,
                     want.block_index, want.image_x, want.image_y, want.image_z,
                     want.done_res);
            $display("                      got idx %0d img %0d/%0d/%0d done %0b",
                     out_item.block_index, out_item.image_x, out_item.image_y,
                     out_item.image_z, out_item.done_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((push && !full) || (pop && !empty))) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int counted;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_wdata = '0;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    send_idle_pct = 30;
    recv_idle_pct = 69;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: x and z periodic, y clamped
    write_reg(CFG_PERIODIC, 32'd5);
    @(negedge clk) cfg_we <= 1'b0;
    n_settings++;
    @(posedge clk);
    add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_BOX, -2 * ONE, -ONE, -2 * ONE, 0, -3 * ONE / 2, ONE / 2, -2 * ONE);
    repeat (3) add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_SPHERE, 5 * ONE / 2, 3 * ONE, 15 * ONE, ONE / 2, 0, 0, 0);
    repeat (3) add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             0, 0, 0);
    add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             0, 0, 0);
    add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_BOX, 5 * ONE, 5 * ONE, 5 * ONE, 0, 3 * ONE, 3 * ONE, 3 * ONE);
    repeat (2) add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    add_item(KIND_BOX, 15 * ONE, 0, 15 * ONE, 0, 16 * ONE, ONE, 16 * ONE);
    repeat (4) add_item(KIND_ADVANCE, 0, 0, 0, 0, 0, 0, 0);
    drain();

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 3)
        0: begin send_idle_pct = 30; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      apply_setting(seg % 6);
      @(posedge clk);
      counted = 0;
      while (counted < SEG_ITEMS) add_random_seq(counted);
      drain();
    end

    $display("Checked %0d results from %0d starts and %0d advances", blocks_checked,
             n_starts, n_advances);
    $display("under %0d register settings and three stall patterns.", n_settings);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
